// ----- rtl/assert_macros.svh -----
// Assertion helper macros for the DDS sine and gated frequency counter RTL.
// Included by modules that carry concurrent checks; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication property checked on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ----- rtl/dsgfc_pkg.sv -----
// Shared types and constants for the DDS sine generator and gated counter.
// No dependencies; used by dsgfc_gate_counter and the top level.
`default_nettype none

package dsgfc_pkg;

  localparam int unsigned CNT_W     = 32;
  localparam int unsigned EDGE_W    = 10;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned ROM_IDX_W = 8;
  localparam int unsigned ROM_DEPTH = 256;

  // Configuration register indexes
  localparam logic CFG_PHASE_STEP = 1'b0;
  localparam logic CFG_GATE_TICKS = 1'b1;

  localparam logic [CNT_W-1:0] PHASE_STEP_RST = 32'h0400_0000;
  localparam logic [CNT_W-1:0] CNT_SAT        = '1;

  // Status handed from the gate counter to the result register
  typedef struct packed {
    logic             measuring;
    logic             done;
    logic [CNT_W-1:0] count;
  } gate_stat_t;

  // One period of sine, centered on 127, peak 254
  localparam logic [SAMPLE_W-1:0] SINE_ROM [ROM_DEPTH] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd178, 8'd181, 8'd184, 8'd187, 8'd190, 8'd192, 8'd195,
    8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd212, 8'd215,
    8'd217, 8'd219, 8'd221, 8'd223, 8'd225, 8'd227, 8'd229, 8'd231,
    8'd233, 8'd234, 8'd236, 8'd238, 8'd239, 8'd240, 8'd242, 8'd243,
    8'd244, 8'd245, 8'd247, 8'd248, 8'd249, 8'd249, 8'd250, 8'd251,
    8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253, 8'd253, 8'd252,
    8'd252, 8'd251, 8'd250, 8'd249, 8'd249, 8'd248, 8'd247, 8'd245,
    8'd244, 8'd243, 8'd242, 8'd240, 8'd239, 8'd238, 8'd236, 8'd234,
    8'd233, 8'd231, 8'd229, 8'd227, 8'd225, 8'd223, 8'd221, 8'd219,
    8'd217, 8'd215, 8'd212, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
    8'd198, 8'd195, 8'd192, 8'd190, 8'd187, 8'd184, 8'd181, 8'd178,
    8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
    8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
    8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
    8'd78,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
    8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
    8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
    8'd21,  8'd20,  8'd18,  8'd16,  8'd15,  8'd14,  8'd12,  8'd11,
    8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
    8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
    8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd16,  8'd18,  8'd20,
    8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
    8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
    8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
    8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
    8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
  };

endpackage

`default_nettype wire

// ----- rtl/dsgfc_gate_counter.sv -----
// Gated edge counter: start latch, tick/edge counters and held result.
// Depends on dsgfc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dsgfc_gate_counter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               step_i,
  input  wire logic                               start_request_i,
  input  wire logic [dsgfc_pkg::EDGE_W-1:0]       edge_count_i,
  input  wire logic [dsgfc_pkg::CNT_W-1:0]        gate_ticks_i,
  output dsgfc_pkg::gate_stat_t                   stat_o
);

  logic                         start_pending_r, start_pending_nxt;
  logic                         gate_open_r, gate_open_nxt;
  logic [dsgfc_pkg::CNT_W-1:0]  tick_counter_r, tick_counter_nxt;
  logic [dsgfc_pkg::CNT_W-1:0]  edge_accum_r, edge_accum_nxt;
  logic [dsgfc_pkg::CNT_W-1:0]  last_count_r, last_count_nxt;
  logic [dsgfc_pkg::CNT_W:0]    edge_sum;
  logic [dsgfc_pkg::CNT_W-1:0]  edge_sat;
  logic                         pend;
  logic                         done;

  // Saturating add of this tick's edges onto the running sum
  assign edge_sum = {1'b0, edge_accum_r} +
                    (dsgfc_pkg::CNT_W + 1)'(edge_count_i);
  assign edge_sat = edge_sum[dsgfc_pkg::CNT_W] ? dsgfc_pkg::CNT_SAT
                                               : edge_sum[dsgfc_pkg::CNT_W-1:0];

  // Gate sequencing for one tick
  always_comb begin
    pend              = start_pending_r | start_request_i;
    start_pending_nxt = pend;
    gate_open_nxt     = gate_open_r;
    tick_counter_nxt  = tick_counter_r;
    edge_accum_nxt    = edge_accum_r;
    last_count_nxt    = last_count_r;
    done              = 1'b0;
    if (gate_open_r) begin
      if (tick_counter_r >= gate_ticks_i) begin
        // close the gate and latch the sum including this tick
        last_count_nxt = edge_sat;
        done           = 1'b1;
        gate_open_nxt  = 1'b0;
      end else begin
        edge_accum_nxt   = edge_sat;
        tick_counter_nxt = tick_counter_r + 1'b1;
      end
    end else if (pend) begin
      // open a fresh gate; this tick's edges are dropped
      start_pending_nxt = 1'b0;
      gate_open_nxt     = 1'b1;
      tick_counter_nxt  = '0;
      edge_accum_nxt    = '0;
    end
  end

  // Advance state once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pending_r <= 1'b0;
      gate_open_r     <= 1'b0;
      tick_counter_r  <= '0;
      edge_accum_r    <= '0;
      last_count_r    <= '0;
    end else if (step_i) begin
      start_pending_r <= start_pending_nxt;
      gate_open_r     <= gate_open_nxt;
      tick_counter_r  <= tick_counter_nxt;
      edge_accum_r    <= edge_accum_nxt;
      last_count_r    <= last_count_nxt;
    end
  end

  // Status after this tick, for the result register
  assign stat_o.measuring = gate_open_nxt;
  assign stat_o.done      = done;
  assign stat_o.count     = last_count_nxt;

  `ASSERT_PROP(a_done_closes, clk, rst_n,
    (step_i && done) |=> !gate_open_r, "gate still open after done")
  `ASSERT_PROP(a_start_clears, clk, rst_n,
    (step_i && !gate_open_r && pend) |=>
      (gate_open_r && tick_counter_r == '0 && edge_accum_r == '0),
    "gate opened without clearing counters")
  `ASSERT_PROP(a_idle_no_pending, clk, rst_n,
    (step_i && !gate_open_r) |=> !start_pending_r,
    "request left pending after an idle tick")
  `ASSERT_PROP(a_hold_no_step, clk, rst_n,
    !step_i |=> ($stable(tick_counter_r) && $stable(last_count_r)),
    "counter state moved without an item")

endmodule

`default_nettype wire

// ----- rtl/dds_sine_and_gated_freq_counter.sv -----
// Top level: DDS phase accumulator with sine lookup, plus gated edge counter.
// Depends on dsgfc_pkg and dsgfc_gate_counter.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    start_request, edge_count
//  out_     out  out_tvalid/out_tready  compare_value, measuring, done_res,
//                                       measured_count
//  cfg_     in   cfg_we                 cfg_addr selects register, cfg_wdata
//
// One item per cycle unless out_tready stalls: the phase add, sine lookup
// and counter update sit between the accepted item and the result register.
// in_tready is high while the result register is empty or being taken, so
// a stalled out_tready holds one result and stops input after it.
// rst_n (synchronous) clears all state but the result payload; no clearing pass is needed.
`default_nettype none

module dds_sine_and_gated_freq_counter #(
  parameter int unsigned TABLE_ADDR_BITS = 8,
  parameter int unsigned ACC_BITS        = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] start_request, [10:1] edge_count, [15:11] zero
  input  wire logic [15:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] compare_value, [8] measuring, [9] done_res,
  // [41:10] measured_count, [47:42] zero
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  logic [dsgfc_pkg::CNT_W-1:0]     phase_step_r;
  logic [dsgfc_pkg::CNT_W-1:0]     gate_ticks_r;
  logic [ACC_BITS-1:0]             phase_acc_r, phase_acc_nxt;
  logic [dsgfc_pkg::ROM_IDX_W-1:0] rom_idx;
  logic                            in_acc;
  logic                            out_tvalid_r;
  logic [dsgfc_pkg::SAMPLE_W-1:0]  compare_r;
  dsgfc_pkg::gate_stat_t           stat;
  dsgfc_pkg::gate_stat_t           stat_r;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= dsgfc_pkg::PHASE_STEP_RST;
      gate_ticks_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        dsgfc_pkg::CFG_PHASE_STEP: phase_step_r <= cfg_wdata;
        dsgfc_pkg::CFG_GATE_TICKS: gate_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Phase accumulator wraps at its own width
  assign phase_acc_nxt = phase_acc_r + ACC_BITS'(phase_step_r);

  // Scale the top accumulator bits to the 8-bit table index
  generate
    if (TABLE_ADDR_BITS >= dsgfc_pkg::ROM_IDX_W) begin : g_idx_wide
      assign rom_idx = phase_acc_nxt[ACC_BITS-1 -: dsgfc_pkg::ROM_IDX_W];
    end else begin : g_idx_narrow
      assign rom_idx = {phase_acc_nxt[ACC_BITS-1 -: TABLE_ADDR_BITS],
                        {(dsgfc_pkg::ROM_IDX_W - TABLE_ADDR_BITS){1'b0}}};
    end
  endgenerate

  dsgfc_gate_counter u_gate (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_i          (in_acc),
    .start_request_i (in_tdata[0]),
    .edge_count_i    (in_tdata[10:1]),
    .gate_ticks_i    (gate_ticks_r),
    .stat_o          (stat)
  );

  // Accumulator and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_acc_r <= phase_acc_nxt;
      end
      if (in_acc) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      compare_r <= dsgfc_pkg::SINE_ROM[rom_idx];
      stat_r    <= stat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, stat_r.count, stat_r.done, stat_r.measuring, compare_r};

endmodule

`default_nettype wire
